// ===== hw/rtl/swstat_pkg.sv =====
// shared constants and types for the sensor window statistics block
package swstat_pkg;

  // history ring and field sizes
  localparam int HistDepth = 4096;
  localparam int AddrW     = $clog2(HistDepth);
  localparam int CntW      = $clog2(HistDepth + 1);
  localparam int SampW     = 12;
  localparam int WinW      = 13;
  localparam int SumW      = SampW + CntW;
  localparam int CmpW      = (WinW > CntW) ? WinW : CntW;
  localparam int DivCntW   = $clog2(SumW + 1);

  localparam logic [WinW-1:0] WinRst = WinW'(16);

  // extreme tracker reset codes
  localparam logic [SampW-1:0] TempMinRst  = 12'h7ff;
  localparam logic [SampW-1:0] TempMaxRst  = 12'h800;
  localparam logic [SampW-1:0] LightMinRst = 12'hfff;
  localparam logic [SampW-1:0] LightMaxRst = 12'h000;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/swstat_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module swstat_div
  import swstat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]    div_q, div_d;
  logic [CntW:0]      trial;

  // one shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[SumW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(SumW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = CntW'(trial - {1'b0, div_q});
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hw/rtl/sensor_window_stats_unit.sv =====
// top level: sample history, extremes, windowed means
//
// Each accepted beat carries one temperature and one light sample. The pair is
// written to a 4096-entry ring history and the all-time extremes are updated at
// once. The block then reads the most recent m = min(window_len, samples stored)
// entries back from the history memory, one per cycle, summing both channels,
// and divides both sums by m in two bit-serial dividers. Each item passes through
// the accept, the memory read sweep and the last sum, the division, and the load
// of the means and the result register; a zero window skips the sweep and the
// division. While the result register is full and stalled, the block waits in
// its done state. One item is worked on at a time; the result sits in an output
// register so the next beat can be taken while it waits. window_len must be
// written through the configuration port only while the block is idle; the
// block itself does not enforce this.
module sensor_window_stats_unit
  import swstat_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic        [WinW-1:0]  cfg_data_i,
  // sample input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SampW-1:0] temp_sample_i,
  input  logic        [SampW-1:0] light_sample_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SampW-1:0] temp_mean_o,
  output logic        [SampW-1:0] light_mean_o,
  output logic signed [SampW-1:0] temp_low_o,
  output logic signed [SampW-1:0] temp_high_o,
  output logic        [SampW-1:0] light_low_o,
  output logic        [SampW-1:0] light_high_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [WinW-1:0]  win_len_q;
  logic [AddrW-1:0] wr_ptr_q;
  logic [CntW-1:0]  fill_q;
  logic [AddrW-1:0] rd_ptr_q;
  logic [CntW-1:0]  issue_left_q;
  logic [CntW-1:0]  win_cnt_q;
  logic             rd_pend_q;
  logic             tneg_q;
  logic             out_valid_q;

  logic [SampW-1:0] tmin_q, tmax_q, lmin_q, lmax_q;
  logic signed [SumW-1:0] sum_t_q;
  logic        [SumW-1:0] sum_l_q;
  logic [SampW-1:0] mean_t_q, mean_l_q;
  logic [SampW-1:0] out_tmean_q, out_lmean_q;
  logic [SampW-1:0] out_tmin_q, out_tmax_q, out_lmin_q, out_lmax_q;

  // history memory, temperature in the upper half of a word
  logic [2*SampW-1:0] hist_mem [HistDepth];
  logic [2*SampW-1:0] rd_data_q;
  logic               wr_en;

  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] fill_d;
  logic [CntW-1:0] win_cnt_d;
  logic            issue;
  logic            can_load;
  div_req_t        t_req, l_req;
  div_rsp_t        t_rsp, l_rsp;
  logic [SumW-1:0] t_mag;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign wr_en       = in_acc;
  assign issue       = (state_q == ST_READ) && (issue_left_q != '0);
  assign can_load    = !out_valid_q || !out_stall_i;

  // fill count after this beat and the clamped window
  always_comb begin
    fill_d = (fill_q == CntW'(HistDepth)) ? fill_q : fill_q + CntW'(1);
    if (CmpW'(win_len_q) > CmpW'(fill_d)) begin
      win_cnt_d = fill_d;
    end else begin
      win_cnt_d = CntW'(win_len_q);
    end
  end

  // divider requests, temperature divides its magnitude
  assign t_mag = sum_t_q[SumW-1] ? SumW'(-sum_t_q) : SumW'(sum_t_q);

  always_comb begin
    t_req.start    = (state_q == ST_READ) && (issue_left_q == '0) && !rd_pend_q;
    t_req.dividend = t_mag;
    t_req.divisor  = win_cnt_q;
    l_req.start    = t_req.start;
    l_req.dividend = sum_l_q;
    l_req.divisor  = win_cnt_q;
  end

  swstat_div u_div_temp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (t_req),
    .rsp_o  (t_rsp)
  );

  swstat_div u_div_light (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (l_req),
    .rsp_o  (l_rsp)
  );

  // history write on accept, registered read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_ptr_q] <= {temp_sample_i, light_sample_i};
    end
    rd_data_q <= hist_mem[rd_ptr_q];
  end

  // control and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      win_len_q    <= WinRst;
      wr_ptr_q     <= '0;
      fill_q       <= '0;
      rd_ptr_q     <= '0;
      issue_left_q <= '0;
      win_cnt_q    <= '0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      tmin_q       <= TempMinRst;
      tmax_q       <= TempMaxRst;
      lmin_q       <= LightMinRst;
      lmax_q       <= LightMaxRst;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_len_q <= cfg_data_i;
      end
      // result register fills from the done state, empties on an accepted beat
      if (state_q == ST_DONE && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      rd_pend_q <= issue;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if ($signed(temp_sample_i) < $signed(tmin_q)) tmin_q <= temp_sample_i;
            if ($signed(temp_sample_i) > $signed(tmax_q)) tmax_q <= temp_sample_i;
            if (light_sample_i < lmin_q) lmin_q <= light_sample_i;
            if (light_sample_i > lmax_q) lmax_q <= light_sample_i;
            wr_ptr_q     <= (wr_ptr_q == AddrW'(HistDepth - 1)) ? '0
                                                                 : wr_ptr_q + AddrW'(1);
            fill_q       <= fill_d;
            rd_ptr_q     <= wr_ptr_q;
            issue_left_q <= win_cnt_d;
            win_cnt_q    <= win_cnt_d;
            state_q      <= (win_cnt_d == '0) ? ST_DONE : ST_READ;
          end
        end
        ST_READ: begin
          if (issue) begin
            issue_left_q <= issue_left_q - CntW'(1);
            rd_ptr_q     <= (rd_ptr_q == '0) ? AddrW'(HistDepth - 1)
                                             : rd_ptr_q - AddrW'(1);
          end
          if (t_req.start) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (t_rsp.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // sums, means and result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_t_q  <= '0;
      sum_l_q  <= '0;
      mean_t_q <= '0;
      mean_l_q <= '0;
    end else if (rd_pend_q) begin
      sum_t_q <= sum_t_q + SumW'($signed(rd_data_q[2*SampW-1:SampW]));
      sum_l_q <= sum_l_q + SumW'(rd_data_q[SampW-1:0]);
    end
    if (t_req.start) begin
      tneg_q <= sum_t_q[SumW-1];
    end
    if (state_q == ST_DIV && t_rsp.done) begin
      mean_t_q <= tneg_q ? SampW'(-t_rsp.quotient[SampW-1:0])
                         : t_rsp.quotient[SampW-1:0];
      mean_l_q <= l_rsp.quotient[SampW-1:0];
    end
    if (state_q == ST_DONE && can_load) begin
      out_tmean_q <= mean_t_q;
      out_lmean_q <= mean_l_q;
      out_tmin_q  <= tmin_q;
      out_tmax_q  <= tmax_q;
      out_lmin_q  <= lmin_q;
      out_lmax_q  <= lmax_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign temp_mean_o  = out_tmean_q;
  assign light_mean_o = out_lmean_q;
  assign temp_low_o   = out_tmin_q;
  assign temp_high_o  = out_tmax_q;
  assign light_low_o  = out_lmin_q;
  assign light_high_o = out_lmax_q;

  // both dividers run in lock step
  assert property (@(posedge clk_i) disable iff (!rst_ni) t_rsp.done == l_rsp.done)
    else $error("divider units out of step");

  // a read sweep never covers more than the stored samples
  assert property (@(posedge clk_i) disable iff (!rst_ni) issue_left_q <= fill_q)
    else $error("history sweep longer than fill count");

  // once a sample is in, low never exceeds high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> ($signed(tmin_q) <= $signed(tmax_q) && lmin_q <= lmax_q))
    else $error("extreme trackers inconsistent");

  // an accepted beat holds off the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> in_stall_o)
    else $error("input taken while busy");

endmodule

// ===== dv/tb.sv =====
// testbench for sensor_window_stats_unit: windowed means and all-time extremes
`timescale 1ns / 1ps

import swstat_pkg::*;

// one expected result beat
typedef struct {
  logic signed [SampW-1:0] t_mean;
  logic        [SampW-1:0] l_mean;
  logic signed [SampW-1:0] t_low;
  logic signed [SampW-1:0] t_high;
  logic        [SampW-1:0] l_low;
  logic        [SampW-1:0] l_high;
} stats_t;

// tracks history, extremes and window, predicts the stats of every accepted sample
class sensor_stats_board;
  logic signed [SampW-1:0] temp_ring[HistDepth];
  logic        [SampW-1:0] light_ring[HistDepth];
  int                      wr_ptr;
  int                      fill;
  int                      window;
  logic signed [SampW-1:0] t_low, t_high;
  logic        [SampW-1:0] l_low, l_high;
  stats_t                  stats_due[$];
  int                      errors;

  function new();
    wr_ptr = 0;
    fill   = 0;
    window = int'(WinRst);
    t_low  = TempMinRst;
    t_high = TempMaxRst;
    l_low  = LightMinRst;
    l_high = LightMaxRst;
    errors = 0;
  endfunction

  function void set_window(logic [WinW-1:0] v);
    window = int'(v);
  endfunction

  // sample beat accepted: update state and queue the stats it must produce
  function void take_sample(logic signed [SampW-1:0] t, logic [SampW-1:0] l);
    stats_t exp_s;
    longint sum_t;
    longint sum_l;
    int     m;
    int     idx;
    if (t < t_low) t_low = t;
    if (t > t_high) t_high = t;
    if (l < l_low) l_low = l;
    if (l > l_high) l_high = l;
    temp_ring[wr_ptr]  = t;
    light_ring[wr_ptr] = l;
    wr_ptr = (wr_ptr + 1) % HistDepth;
    if (fill < HistDepth) fill++;
    // window clamps to what has been stored
    m = (window > fill) ? fill : window;
    sum_t = 0;
    sum_l = 0;
    for (int i = 0; i < m; i++) begin
      idx = (wr_ptr + HistDepth - 1 - i) % HistDepth;
      sum_t += longint'(temp_ring[idx]);
      sum_l += longint'({1'b0, light_ring[idx]});
    end
    exp_s.t_mean = (m == 0) ? '0 : SampW'(sum_t / longint'(m));
    exp_s.l_mean = (m == 0) ? '0 : SampW'(sum_l / longint'(m));
    exp_s.t_low  = t_low;
    exp_s.t_high = t_high;
    exp_s.l_low  = l_low;
    exp_s.l_high = l_high;
    stats_due.push_back(exp_s);
  endfunction

  function void cmp_field(string name, logic [SampW-1:0] exp_v, logic [SampW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 'h%03h, got 'h%03h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result beat accepted: compare against the oldest prediction
  function void check_stats(stats_t act);
    stats_t exp_s;
    if (stats_due.size() == 0) begin
      $error("result beat with no sample outstanding");
      errors++;
      return;
    end
    exp_s = stats_due.pop_front();
    cmp_field("temp_mean", exp_s.t_mean, act.t_mean);
    cmp_field("light_mean", exp_s.l_mean, act.l_mean);
    cmp_field("temp_low", exp_s.t_low, act.t_low);
    cmp_field("temp_high", exp_s.t_high, act.t_high);
    cmp_field("light_low", exp_s.l_low, act.l_low);
    cmp_field("light_high", exp_s.l_high, act.l_high);
  endfunction
endclass

module tb;

  // no-progress limit well above one full-window item plus the final drain
  localparam int QuietLimit  = 50000;
  localparam int DrainCycles = 4200;
  localparam int IdlePct     = 15;
  localparam int RandItems   = 105;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic        [WinW-1:0]  cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [SampW-1:0] temp_sample_i;
  logic        [SampW-1:0] light_sample_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [SampW-1:0] temp_mean_o;
  logic        [SampW-1:0] light_mean_o;
  logic signed [SampW-1:0] temp_low_o;
  logic signed [SampW-1:0] temp_high_o;
  logic        [SampW-1:0] light_low_o;
  logic        [SampW-1:0] light_high_o;

  sensor_stats_board board;
  logic              calm;
  int                quiet_cycles;

  sensor_window_stats_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .temp_sample_i  (temp_sample_i),
    .light_sample_i (light_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .temp_mean_o    (temp_mean_o),
    .light_mean_o   (light_mean_o),
    .temp_low_o     (temp_low_o),
    .temp_high_o    (temp_high_o),
    .light_low_o    (light_low_o),
    .light_high_o   (light_high_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // random backpressure on the result side
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  // result monitor and no-progress watchdog
  always @(posedge clk_i) begin
    stats_t act;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        act.t_mean = temp_mean_o;
        act.l_mean = light_mean_o;
        act.t_low  = temp_low_o;
        act.t_high = temp_high_o;
        act.l_low  = light_low_o;
        act.l_high = light_high_o;
        board.check_stats(act);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // drive one sample beat, with random idle cycles ahead of it
  task automatic send_sample(input logic signed [SampW-1:0] t, input logic [SampW-1:0] l);
    while (!calm && ($urandom_range(99) < IdlePct)) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    temp_sample_i  <= t;
    light_sample_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    board.take_sample(t, l);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.stats_due.size() != 0) @(posedge clk_i);
  endtask

  // window length write, only with the block idle
  task automatic write_window(input logic [WinW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_window(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly in -550 to 1500, sometimes any 12-bit code
  function automatic logic signed [SampW-1:0] rand_temp();
    int v;
    if ($urandom_range(9) < 7) v = int'($urandom_range(2050)) - 550;
    else v = int'($urandom_range(4095));
    return SampW'(v);
  endfunction

  function automatic logic [SampW-1:0] rand_light();
    if ($urandom_range(9) < 7) return SampW'($urandom_range(3300));
    return SampW'($urandom_range(4095));
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_sample(rand_temp(), rand_light());
  endtask

  initial begin
    int left;
    int n;
    int pick;
    int phase;
    logic [WinW-1:0] win;
    board          = new();
    calm           = 1'b0;
    quiet_cycles   = 0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    temp_sample_i  = '0;
    light_sample_i = '0;
    out_stall_i    = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset window of 16, clamped to the few samples stored so far
    send_sample(-12'sd2048, 12'd0);
    send_sample(12'sd2047, 12'd4095);
    send_sample(-12'sd550, 12'd3300);
    send_sample(12'sd1500, 12'd0);
    send_sample(12'sd0, 12'd1);
    send_sample(-12'sd1, 12'd4094);
    send_sample(12'sh555, 12'haaa);
    send_sample(-12'sd1366, 12'h555);

    // zero window gives zero means
    write_window(WinW'(0));
    send_sample(-12'sd2048, 12'd4095);
    send_sample(12'sd2047, 12'd0);
    send_sample(12'sd7, 12'd9);

    // negative mean truncates toward zero
    write_window(WinW'(2));
    send_sample(-12'sd3, 12'd5);
    send_sample(-12'sd4, 12'd6);
    send_sample(12'sd1, 12'd2);
    send_sample(-12'sd8, 12'd1);

    // full-size window, far longer than the history stored
    write_window(WinW'(HistDepth));
    send_sample(-12'sd2048, 12'd4095);
    send_sample(12'sd2047, 12'd4095);
    send_sample(-12'sd2048, 12'd0);

    // random phases, each with its own window length
    left  = RandItems;
    phase = 0;
    while (left > 0) begin
      n = $urandom_range(8, 24);
      if (n > left) n = left;
      pick = $urandom_range(19);
      if (pick == 0) win = '0;
      else if (pick < 12) win = WinW'($urandom_range(1, 16));
      else if (pick < 17) win = WinW'($urandom_range(17, 300));
      else if (pick == 17) win = WinW'(HistDepth);
      else win = WinW'($urandom);
      write_window(win);
      calm = (phase == 3);
      send_random(n);
      calm = 1'b0;
      left -= n;
      phase++;
    end

    // largest windows, clamped to the samples stored, then a window of one
    write_window(WinW'(HistDepth));
    send_random(5);
    write_window('1);
    send_random(3);
    write_window(WinW'(HistDepth - 1));
    send_random(3);
    write_window(WinW'(1));
    send_random(4);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.stats_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swstat_pkg.sv
hw/rtl/swstat_div.sv
hw/rtl/sensor_window_stats_unit.sv
dv/tb.sv
